/* design/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared codes and types for the circular deque: operation kinds, result
// status codes and the control word broadcast along the cell chains.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int WORD_W = 32;

  localparam logic [1:0] KIND_PUSH_BACK  = 2'd0;
  localparam logic [1:0] KIND_PUSH_FRONT = 2'd1;
  localparam logic [1:0] KIND_POP_BACK   = 2'd2;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // What every cell of a chain does
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_FROM_LEFT,
    OP_FROM_RIGHT,
    OP_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   din;
  } cell_ctl_t;

endpackage

/* design/cdq_cell.sv */
// ----------------------------------------------------------------------------
// cdq_cell
// One word of a deque chain. Holds, takes its left or right neighbor, or
// loads the broadcast word when the target position names this cell.
// ----------------------------------------------------------------------------
module cdq_cell import cdq_pkg::*; #(
  parameter int IW  = 7,
  parameter int POS = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IW-1:0]     target,
  input  logic [WORD_W-1:0] left,
  input  logic [WORD_W-1:0] right,
  output logic [WORD_W-1:0] q
);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_HOLD:       q <= q;
      OP_FROM_LEFT:  q <= left;
      OP_FROM_RIGHT: q <= right;
      OP_LOAD: begin
        if (target == IW'(POS)) begin
          q <= ctl.din;
        end
      end
      default:       q <= q;
    endcase
  end

endmodule

/* design/cdq_chain.sv */
// ----------------------------------------------------------------------------
// cdq_chain
// A row of DEPTH cells. The broadcast word enters at both ends of the row;
// only cell 0 is read.
// ----------------------------------------------------------------------------
module cdq_chain import cdq_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int IW    = 7
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [IW-1:0]     target,
  output logic [WORD_W-1:0] head
);

  logic [WORD_W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_in;
    logic [WORD_W-1:0] right_in;

    if (i == 0) begin : g_left_end
      assign left_in = ctl.din;
    end else begin : g_left_mid
      assign left_in = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_end
      assign right_in = ctl.din;
    end else begin : g_right_mid
      assign right_in = q[i+1];
    end

    cdq_cell #(
      .IW  (IW),
      .POS (i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .target (target),
      .left   (left_in),
      .right  (right_in),
      .q      (q[i])
    );
  end

  assign head = q[0];

endmodule

/* design/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words, push and pop at either end.
// ----------------------------------------------------------------------------
// The result beat appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle while the result side takes its beats;
// the result register is the only stage between the two sides.
// Two cell chains hold the words, one in front-to-back order and one mirrored,
// so each end sits in cell 0 of a chain.
// Reset clears the entry count and the result valid; cell contents are not
// reset, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pop_value,
  output logic [1:0]         status
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  logic              full;
  logic              empty;
  logic              is_push;
  cell_ctl_t         fctl;
  cell_ctl_t         bctl;
  logic [IW-1:0]     tgt;
  logic [WORD_W-1:0] fhead;
  logic [WORD_W-1:0] bhead;
  logic [WORD_W-1:0] res_value;
  logic [1:0]        res_status;

  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);
  assign is_push    = (kind == KIND_PUSH_BACK) || (kind == KIND_PUSH_FRONT);

  // Front chain: cells 0..count-1, front word in cell 0.
  // Back chain: cells 0..count-1, back word in cell 0, front word in the last.
  always_comb begin
    fctl.op    = OP_HOLD;
    fctl.din   = push_value;
    bctl.op    = OP_HOLD;
    bctl.din   = push_value;
    tgt        = count[IW-1:0];
    count_next = count;
    res_value  = '0;
    res_status = ST_OK;
    if (accept) begin
      unique case (kind)
        KIND_PUSH_BACK: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            fctl.op    = OP_LOAD;
            bctl.op    = OP_FROM_LEFT;
            count_next = count + 1'b1;
          end
        end
        KIND_PUSH_FRONT: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            fctl.op    = OP_FROM_LEFT;
            bctl.op    = OP_LOAD;
            count_next = count + 1'b1;
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            res_status = ST_EMPTY;
            res_value  = '1;
          end else begin
            bctl.op    = OP_FROM_RIGHT;
            res_value  = bhead;
            count_next = count - 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            res_status = ST_EMPTY;
            res_value  = '1;
          end else begin
            fctl.op    = OP_FROM_RIGHT;
            res_value  = fhead;
            count_next = count - 1'b1;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  cdq_chain #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_front (
    .clk    (clk),
    .ctl    (fctl),
    .target (tgt),
    .head   (fhead)
  );

  cdq_chain #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_back (
    .clk    (clk),
    .ctl    (bctl),
    .target (tgt),
    .head   (bhead)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_value <= res_value;
      status    <= res_status;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_refused_push: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && full) |=> (count == $past(count)) && (status == ST_FULL))
    else $error("refused push changed the count or reported wrong status");

  a_underflow_value: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_push && empty) |=> (pop_value == '1) && (count == '0))
    else $error("underflow did not return all ones");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_push && !empty) |=> (count == $past(count) - 1'b1))
    else $error("successful pop did not drop the count");

endmodule
